>>> rtl/core/cablk_pkg.sv
// ----------------------------------------------------------------------------
// cablk_pkg
// Shared types and constants for the cable length kinematics block.
// ----------------------------------------------------------------------------
package cablk_pkg;

   // pose store: nine rotation words row-major, then translation x, y, z
   localparam int POSE_WORDS = 12;
   localparam int POSE_IDX_W = 4;
   localparam int TRANS_BASE = 9;
   localparam int AXES       = 3;

   localparam logic [31:0] ONE_Q16    = 32'h0001_0000;
   localparam logic [23:0] GAIN_RESET = 24'd187673;

   // square root unit widths
   localparam int RAD_W  = 64;
   localparam int ROOT_W = 32;
   localparam int STEP_W = 5;

   typedef enum logic {
      CMD_POSE  = 1'b0,
      CMD_CABLE = 1'b1
   } command_type;

endpackage

>>> rtl/core/cablk_isqrt.sv
// ----------------------------------------------------------------------------
// cablk_isqrt
// Bit-serial integer square root: one result bit per cycle, floor result.
// ----------------------------------------------------------------------------
module cablk_isqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [cablk_pkg::RAD_W-1:0]    radicand,
   output logic                           done,
   output logic [cablk_pkg::ROOT_W-1:0]   root
);

   localparam int REM_W = cablk_pkg::ROOT_W + 3;

   logic                            busy_ff,  busy_in;
   logic                            done_ff,  done_in;
   logic [cablk_pkg::STEP_W-1:0]    count_ff, count_in;
   logic [cablk_pkg::RAD_W-1:0]     rad_ff,   rad_in;
   logic [REM_W-1:0]                rem_ff,   rem_in;
   logic [cablk_pkg::ROOT_W-1:0]    root_ff,  root_in;

   logic [REM_W-1:0]                rem_shift;
   logic [REM_W-1:0]                trial;
   logic                            fits;

   // one restoring step: bring down two radicand bits, try root*4+1
   assign rem_shift = {rem_ff[REM_W-3:0], rad_ff[cablk_pkg::RAD_W-1 -: 2]};
   assign trial     = {1'b0, root_ff, 2'b01};
   assign fits      = (rem_shift >= trial);

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rad_in   = radicand;
         rem_in   = '0;
         root_in  = '0;
      end else if (busy_ff) begin
         rad_in   = {rad_ff[cablk_pkg::RAD_W-3:0], 2'b00};
         rem_in   = fits ? (rem_shift - trial) : rem_shift;
         root_in  = {root_ff[cablk_pkg::ROOT_W-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == cablk_pkg::STEP_W'(cablk_pkg::ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      count_ff <= count_in;
      rad_ff   <= rad_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

>>> rtl/core/cable_length_kinematics_top.sv
// ----------------------------------------------------------------------------
// cable_length_kinematics_top
// Cable length and joint value from a stored platform pose, using one shared
// multiplier under a small sequencer and a bit-serial square root.
// ----------------------------------------------------------------------------
// Sequence: per axis a load step, three multiply and accumulate steps on the
//   shared multiplier, a square and a sum; then 32 square root steps, a step to
//   take the root, the gain product, plus any wait for the response slot.
// Throughput: one request at a time, ready only while idle: no new cable request
//   until the last response is loaded, a pose write every cycle.
// Reset: identity pose, zero translation, gain 187673, no response pending.
module cable_length_kinematics_top (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [0:0]         req_command,
   input  logic [3:0]         req_pose_index,
   input  logic signed [31:0] req_pose_value,
   input  logic signed [31:0] req_base_x,
   input  logic signed [31:0] req_base_y,
   input  logic signed [31:0] req_base_z,
   input  logic signed [31:0] req_plat_x,
   input  logic signed [31:0] req_plat_y,
   input  logic signed [31:0] req_plat_z,
   input  logic [2:0]         req_cable_index,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_cable_id,
   output logic [31:0]        rsp_cable_len,
   output logic [31:0]        rsp_joint_value,
   output logic               rsp_overflow,
   // gain register
   input  logic               csr_wr_en,
   input  logic [23:0]        csr_wr_data
);

   localparam int ACC_W  = 52;
   localparam int MUL_W  = 33;
   localparam int PROD_W = 2 * MUL_W;

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_LOAD = 9'b000000010,
      ST_MUL  = 9'b000000100,
      ST_ACC  = 9'b000001000,
      ST_SQ   = 9'b000010000,
      ST_SUM  = 9'b000100000,
      ST_ROOT = 9'b001000000,
      ST_JMUL = 9'b010000000,
      ST_JFIN = 9'b100000000
   } state_type;

   state_type                 state_ff, state_in;
   logic [1:0]                i_ff, i_in;
   logic [1:0]                j_ff, j_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic [63:0]               sum_ff, sum_in;
   logic                      ovf_ff, ovf_in;
   logic [31:0]               len_ff, len_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic [23:0]               gain_ff;
   logic [31:0]               pose_ff [cablk_pkg::POSE_WORDS];
   logic signed [31:0]        a_ff [cablk_pkg::AXES];
   logic signed [31:0]        b_ff [cablk_pkg::AXES];
   logic [2:0]                cid_ff;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [2:0]                rsp_cid_ff;
   logic [31:0]               rsp_len_ff;
   logic [31:0]               rsp_joint_ff;
   logic                      rsp_ovf_ff;

   logic                      req_fire;
   logic                      rsp_load;
   logic                      sqrt_start;
   logic                      sqrt_done;
   logic [31:0]               sqrt_root;

   logic [cablk_pkg::POSE_IDX_W-1:0] rot_idx;
   logic [cablk_pkg::POSE_IDX_W-1:0] trans_idx;
   logic signed [31:0]        a_sel;
   logic signed [31:0]        b_sel;
   logic signed [31:0]        t_sel;
   logic signed [MUL_W-1:0]   op_a;
   logic signed [MUL_W-1:0]   op_b;
   logic signed [ACC_W-1:0]   prod_term;
   logic [ACC_W-1:0]          acc_mag;
   logic                      mag_big;
   logic [64:0]               sum_add;
   logic [39:0]               joint_full;
   logic                      joint_sat;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid & req_ready;

   // pose word and operand selection
   assign rot_idx   = cablk_pkg::POSE_IDX_W'({2'b00, i_ff} * 4'd3)
                      + {2'b00, j_ff};
   assign trans_idx = cablk_pkg::POSE_IDX_W'(cablk_pkg::TRANS_BASE)
                      + {2'b00, i_ff};
   assign t_sel     = pose_ff[trans_idx];
   assign a_sel     = a_ff[i_ff];
   assign b_sel     = b_ff[j_ff];

   // floor(product / 2^16), sign-extended into the accumulator
   assign prod_term = {{4{prod_ff[63]}}, prod_ff[63:16]};
   assign acc_mag   = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : acc_ff;
   assign mag_big   = |acc_mag[ACC_W-1:32];
   assign sum_add   = {1'b0, sum_ff} + {1'b0, prod_ff[63:0]};

   // joint = floor(len * gain / 2^16), saturated to 32 bits
   assign joint_full = prod_ff[55:16];
   assign joint_sat  = |joint_full[39:32];

   // shared multiplier operand select
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (state_ff)
         ST_MUL: begin
            op_a = {pose_ff[rot_idx][31], pose_ff[rot_idx]};
            op_b = {b_sel[31], b_sel};
         end
         ST_SQ: begin
            op_a = {1'b0, acc_mag[31:0]};
            op_b = {1'b0, acc_mag[31:0]};
         end
         ST_JMUL: begin
            op_a = {1'b0, len_ff};
            op_b = {9'd0, gain_ff};
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign prod_in = op_a * op_b;

   // sequencer
   always_comb begin
      state_in   = state_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      acc_in     = acc_ff;
      sum_in     = sum_ff;
      ovf_in     = ovf_ff;
      len_in     = len_ff;
      sqrt_start = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_command == cablk_pkg::CMD_CABLE)) begin
               state_in = ST_LOAD;
               i_in     = '0;
               sum_in   = '0;
               ovf_in   = 1'b0;
            end
         end
         ST_LOAD: begin
            acc_in   = ACC_W'(t_sel) - ACC_W'(a_sel);
            j_in     = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            acc_in = acc_ff + prod_term;
            if (j_ff == 2'd2) begin
               state_in = ST_SQ;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_SQ: begin
            if (mag_big) begin
               ovf_in = 1'b1;
            end
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (!mag_big) begin
               sum_in = sum_add[63:0];
               if (sum_add[64]) begin
                  ovf_in = 1'b1;
               end
            end
            if (i_ff == 2'd2) begin
               sqrt_start = 1'b1;
               state_in   = ST_ROOT;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_ROOT: begin
            if (sqrt_done) begin
               len_in   = ovf_ff ? '1 : sqrt_root;
               state_in = ST_JMUL;
            end
         end
         ST_JMUL: begin
            state_in = ST_JFIN;
         end
         ST_JFIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_ready);

   // control state, pose store and gain
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         gain_ff      <= cablk_pkg::GAIN_RESET;
         // identity rotation on the diagonal words, zero elsewhere
         for (int k = 0; k < cablk_pkg::POSE_WORDS; k++) begin
            pose_ff[k] <= (k == 0 || k == 4 || k == 8) ? cablk_pkg::ONE_Q16 : '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            gain_ff <= csr_wr_data;
         end
         if (req_fire && (req_command == cablk_pkg::CMD_POSE) &&
             (req_pose_index < cablk_pkg::POSE_IDX_W'(cablk_pkg::POSE_WORDS))) begin
            pose_ff[req_pose_index] <= req_pose_value;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      i_ff    <= i_in;
      j_ff    <= j_in;
      acc_ff  <= acc_in;
      sum_ff  <= sum_in;
      ovf_ff  <= ovf_in;
      len_ff  <= len_in;
      // gain product stays put while the response slot is busy
      if (state_ff != ST_JFIN) begin
         prod_ff <= prod_in;
      end
      if (req_fire) begin
         a_ff[0] <= req_base_x;
         a_ff[1] <= req_base_y;
         a_ff[2] <= req_base_z;
         b_ff[0] <= req_plat_x;
         b_ff[1] <= req_plat_y;
         b_ff[2] <= req_plat_z;
         cid_ff  <= req_cable_index;
      end
      if (rsp_load) begin
         rsp_cid_ff   <= cid_ff;
         rsp_len_ff   <= len_ff;
         rsp_joint_ff <= joint_sat ? '1 : joint_full[31:0];
         rsp_ovf_ff   <= ovf_ff | joint_sat;
      end
   end

   cablk_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sum_in),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cable_id    = rsp_cid_ff;
   assign rsp_cable_len   = rsp_len_ff;
   assign rsp_joint_value = rsp_joint_ff;
   assign rsp_overflow    = rsp_ovf_ff;

`ifndef SYNTHESIS
   // a new response only comes out of the final gain step
   a_rsp_from_jfin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_JFIN))
      else $error("response raised outside final step");

   // overflow with an unsaturated length means the joint value saturated
   a_ovf_joint: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ovf_ff && (rsp_len_ff != '1)) |-> (rsp_joint_ff == '1))
      else $error("overflow flag without saturated output");

   // a saturated sum forces the length to all ones
   a_len_sat: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROOT && sqrt_done && ovf_ff) |=> (len_ff == '1))
      else $error("length not saturated on overflow");

   // a pose write lands in the addressed word
   a_pose_write: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_command == cablk_pkg::CMD_POSE) && (req_pose_index < 4'd12))
      |=> (pose_ff[$past(req_pose_index)] == $past(req_pose_value)))
      else $error("pose word not written");
`endif

endmodule
